// ----- rtl/core/e2g_pkg.sv -----
`timescale 1ns / 1ps

package e2g_pkg;

   // Default field widths.
   localparam int DEF_COORD_BITS = 38;
   localparam int DEF_ANGLE_BITS = 32;

   // Internal datapath widths.
   localparam int WORD_BITS = 64;
   localparam int WIDE_BITS = 128;
   localparam int FRAC      = 40;

   // Configuration register widths and reset values.
   localparam int AXIS_BITS = 37;
   localparam int ECC_BITS  = 40;
   localparam int TOL_BITS  = 10;
   localparam int LIM_BITS  = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 40;

   localparam logic [AXIS_BITS-1:0] AXIS_RESET = 37'd63781370000;
   localparam logic [ECC_BITS-1:0]  ECC_RESET  = 40'd7360548640;
   localparam logic [TOL_BITS-1:0]  TOL_RESET  = 10'd1;
   localparam logic [LIM_BITS-1:0]  LIM_RESET  = 5'd10;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ECC  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOL  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LIM  = 2'd3;

   // Fixed-point constants.
   localparam logic [WORD_BITS-1:0] ONE_Q     = 64'd1 << FRAC;
   localparam logic [WORD_BITS-1:0] HALF_PI_U = 64'd1 << 60;
   localparam logic [WORD_BITS-1:0] PI_U      = 64'd1 << 61;
   localparam logic [WORD_BITS-1:0] TWO_OVER_PI = 64'hA2F9836E4E441529;

   // Rotation table of the angle unit.
   localparam int CORDIC_N = 60;
   typedef logic [WORD_BITS-1:0] atan_tab_type [CORDIC_N];

   // atan(2^-i) in units of pi/2^61, from a Q62 series scaled by 2/pi.
   function automatic atan_tab_type build_atan();
      atan_tab_type tab;
      logic [WORD_BITS-1:0] sum;
      logic [WORD_BITS-1:0] term;
      logic [WIDE_BITS-1:0] prod;
      int e;
      int i;
      int k;
      tab[0] = 64'd1 << 59;
      for (i = 1; i < CORDIC_N; i++) begin
         sum = '0;
         for (k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
               term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
               if ((k % 2) == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
         prod = {64'd0, sum} * {64'd0, TWO_OVER_PI};
         tab[i] = {2'b00, prod[127:66]};
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan();

   // Magnitude of a two's complement word, wrapping at the most negative value.
   function automatic logic [WORD_BITS-1:0] mag64(logic [WORD_BITS-1:0] v);
      return v[WORD_BITS-1] ? (~v + 64'd1) : v;
   endfunction

endpackage

// ----- rtl/core/e2g_mul.sv -----
`timescale 1ns / 1ps

module e2g_mul
   import e2g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   output logic                 done,
   output logic [WIDE_BITS-1:0] prod
);

   logic [WIDE_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] mcand_ff, mcand_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS:0]   sum;

   // Shift-and-add, one multiplier bit a cycle from the low end.
   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      sum = {1'b0, acc_ff[WIDE_BITS-1:WORD_BITS]}
            + (acc_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         acc_in   = {64'd0, op_b};
         mcand_in = op_a;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[WORD_BITS-1:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      cnt_ff   <= cnt_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- rtl/core/e2g_div.sv -----
`timescale 1ns / 1ps

module e2g_div
   import e2g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDE_BITS-1:0] num,
   input  logic [WORD_BITS-1:0] den,
   output logic                 done,
   output logic [WORD_BITS-1:0] quot
);

   logic [WIDE_BITS-1:0] num_ff, num_in;
   logic [WORD_BITS-1:0] den_ff, den_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS:0]   rem_sh;
   logic                 take;

   // Restoring division, one quotient bit a cycle shifted in behind the numerator.
   // A zero divisor yields all ones naturally.
   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, num_ff[WIDE_BITS-1]};
      take    = rem_sh >= {1'b0, den_ff};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? 64'(rem_sh - {1'b0, den_ff}) : rem_sh[WORD_BITS-1:0];
         num_in = {num_ff[WIDE_BITS-2:0], take};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   // Quotients beyond 64 bits saturate.
   assign done = done_ff;
   assign quot = (|num_ff[WIDE_BITS-1:WORD_BITS]) ? '1 : num_ff[WORD_BITS-1:0];

endmodule

// ----- rtl/core/e2g_sqrt.sv -----
`timescale 1ns / 1ps

module e2g_sqrt
   import e2g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDE_BITS-1:0] rad,
   output logic                 done,
   output logic [WORD_BITS-1:0] root
);

   logic [WIDE_BITS-1:0] src_ff, src_in;
   logic [WORD_BITS:0]   rem_ff, rem_in;
   logic [WORD_BITS-1:0] root_ff, root_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS+2:0] rem_sh;
   logic [WORD_BITS+2:0] trial;
   logic                 take;

   // Digit-by-digit floor square root, two radicand bits a cycle.
   always_comb begin
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, src_ff[WIDE_BITS-1:WIDE_BITS-2]};
      trial   = {1'b0, root_ff, 2'b01};
      take    = rem_sh >= trial;
      if (start) begin
         src_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? 65'(rem_sh - trial) : rem_sh[WORD_BITS:0];
         root_in = {root_ff[WORD_BITS-2:0], take};
         src_in  = {src_ff[WIDE_BITS-3:0], 2'b00};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/core/e2g_cordic.sv -----
`timescale 1ns / 1ps

module e2g_cordic
   import e2g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] py,
   input  logic [WORD_BITS-1:0] px,
   output logic                 done,
   output logic [WORD_BITS-1:0] angle
);

   typedef enum logic [1:0] {
      C_IDLE,
      C_NORM,
      C_ROT,
      C_FIX
   } cstate_type;

   cstate_type           state_ff, state_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] ang_ff, ang_in;
   logic [5:0]           i_ff, i_in;
   logic                 xneg_ff, xneg_in;
   logic                 yneg_ff, yneg_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS-1:0] m;
   logic [WORD_BITS-1:0] ax;
   logic [WORD_BITS-1:0] ay;
   logic [WORD_BITS-1:0] xs;
   logic [WORD_BITS-1:0] ys;
   logic [WORD_BITS-1:0] fa;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      a_in     = a_ff;
      ang_in   = ang_ff;
      i_in     = i_ff;
      xneg_in  = xneg_ff;
      yneg_in  = yneg_ff;
      done_in  = 1'b0;
      ax = mag64(px);
      ay = mag64(py);
      m  = (x_ff > y_ff) ? x_ff : y_ff;
      xs = 64'($signed(x_ff) >>> i_ff);
      ys = 64'($signed(y_ff) >>> i_ff);
      fa = a_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in    = ax;
               y_in    = ay;
               a_in    = '0;
               xneg_in = px[WORD_BITS-1];
               yneg_in = py[WORD_BITS-1];
               // A zero vector skips straight to the fix-up with a zero angle.
               state_in = ((ax == '0) && (ay == '0)) ? C_FIX : C_NORM;
            end
         end
         // Bring the larger magnitude into [2^57, 2^58), one bit a cycle.
         C_NORM: begin
            if (|m[WORD_BITS-1:58]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
            end else if (!m[57]) begin
               x_in = x_ff << 1;
               y_in = y_ff << 1;
            end else begin
               i_in     = '0;
               state_in = C_ROT;
            end
         end
         // One vectoring micro-rotation a cycle.
         C_ROT: begin
            if (!y_ff[WORD_BITS-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               a_in = a_ff + ATAN_TAB[i_ff];
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               a_in = a_ff - ATAN_TAB[i_ff];
            end
            i_in = i_ff + 6'd1;
            if (i_ff == 6'(CORDIC_N - 1)) begin
               state_in = C_FIX;
            end
         end
         // Clamp to the first quadrant, then map to the quadrant of the input.
         C_FIX: begin
            if (fa[WORD_BITS-1]) begin
               fa = '0;
            end else if ($signed(fa) > $signed(HALF_PI_U)) begin
               fa = HALF_PI_U;
            end
            if (xneg_ff) begin
               fa = PI_U - fa;
            end
            if (yneg_ff) begin
               fa = ~fa + 64'd1;
            end
            ang_in   = fa;
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      a_ff    <= a_in;
      ang_ff  <= ang_in;
      i_ff    <= i_in;
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
   end

   assign done  = done_ff;
   assign angle = ang_ff;

endmodule

// ----- rtl/core/ecef_to_geodetic_core.sv -----
`timescale 1ns / 1ps

// Converts one Earth-centred position (x, y, z in 0.1 mm) into geodetic latitude, longitude
// (binary angles) and ellipsoidal height, with a flag when the z refinement does not settle
// within the iteration limit. One request is worked at a time under a sequencer that drives
// a shared bit-serial multiplier, divider, square root and CORDIC angle unit. A request
// takes set-up, height and radius work, one refinement pass after another, and two angle
// passes. A new request is taken while a finished response still waits on its output.
module ecef_to_geodetic_core
   import e2g_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic clock,
   input  logic reset,

   // Request: ecef_x, ecef_y, ecef_z from the lowest bit up, zero padded.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]    req_tdata,

   // Response: latitude, longitude, height from the lowest bit up, zero padded.
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [((2*ANGLE_BITS+COORD_BITS+7)/8)*8-1:0]  rsp_tdata,
   // Response flag: not_converged.
   output logic                                          rsp_tuser,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int RSP_W = ((2*ANGLE_BITS+COORD_BITS+7)/8)*8;
   localparam int PAD_W = RSP_W - 2*ANGLE_BITS - COORD_BITS;
   localparam int SH    = 62 - ANGLE_BITS;
   localparam logic [WORD_BITS-1:0] H_MAX = (64'd1 << (COORD_BITS - 1)) - 64'd1;
   localparam logic [WORD_BITS-1:0] H_MIN = ~H_MAX;

   typedef enum logic [4:0] {
      S_IDLE,
      S_WAIT,
      S_R2B,
      S_R2C,
      S_CHECK,
      S_DSQ,
      S_SDIV,
      S_SCLAMP,
      S_S2,
      S_T,
      S_SQ,
      S_V,
      S_C1,
      S_C2,
      S_ZUP,
      S_HSQ,
      S_HDONE,
      S_RHO,
      S_LAT,
      S_LON,
      S_OUT
   } state_type;

   // Rounds an angle in pi/2^61 to the output unit, half away from zero.
   function automatic logic [ANGLE_BITS-1:0] angle_field(logic [WORD_BITS-1:0] a);
      logic [WORD_BITS-1:0] r;
      logic [WORD_BITS-1:0] res;
      r   = (mag64(a) + (64'd1 << (SH - 1))) >> SH;
      res = a[WORD_BITS-1] ? (~r + 64'd1) : r;
      return res[ANGLE_BITS-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] sext(logic [COORD_BITS-1:0] f);
      return {{(WORD_BITS-COORD_BITS){f[COORD_BITS-1]}}, f};
   endfunction

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [AXIS_BITS-1:0] axis_ff, axis_in;
   logic [ECC_BITS-1:0]  ecc_ff, ecc_in;
   logic [TOL_BITS-1:0]  tol_ff, tol_in;
   logic [LIM_BITS-1:0]  lim_ff, lim_in;

   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] zin_ff, zin_in;
   logic [WORD_BITS-1:0] z_ff, z_in;
   logic [WORD_BITS-1:0] zk_ff, zk_in;
   logic [WORD_BITS-1:0] v_ff, v_in;
   logic [WORD_BITS-1:0] s_ff, s_in;
   logic [WORD_BITS-1:0] h_ff, h_in;
   logic [WIDE_BITS-1:0] r2_ff, r2_in;
   logic [LIM_BITS-1:0]  it_ff, it_in;
   logic                 nc_ff, nc_in;
   logic [ANGLE_BITS-1:0] lat_ff, lat_in;
   logic [ANGLE_BITS-1:0] lon_ff, lon_in;

   logic [WORD_BITS-1:0] opa_ff, opa_in;
   logic [WORD_BITS-1:0] opb_ff, opb_in;
   logic [WIDE_BITS-1:0] opn_ff, opn_in;
   logic mul_go_ff, mul_go_in;
   logic div_go_ff, div_go_in;
   logic sqrt_go_ff, sqrt_go_in;
   logic cor_go_ff, cor_go_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_BITS-1:0] rsp_lat_ff, rsp_lat_in;
   logic [ANGLE_BITS-1:0] rsp_lon_ff, rsp_lon_in;
   logic [COORD_BITS-1:0] rsp_h_ff, rsp_h_in;
   logic                  rsp_nc_ff, rsp_nc_in;

   logic                 mul_done;
   logic [WIDE_BITS-1:0] mul_prod;
   logic                 div_done;
   logic [WORD_BITS-1:0] div_quot;
   logic                 sqrt_done;
   logic [WORD_BITS-1:0] sqrt_root;
   logic                 cor_done;
   logic [WORD_BITS-1:0] cor_angle;

   logic [WORD_BITS-1:0] diff;
   logic [WORD_BITS-1:0] mid;
   logic [WORD_BITS-1:0] hd;

   e2g_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go_ff),
      .op_a  (opa_ff),
      .op_b  (opb_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   e2g_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (opn_ff),
      .den   (opa_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   e2g_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_go_ff),
      .rad   (opn_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   e2g_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_go_ff),
      .py    (opa_ff),
      .px    (opb_ff),
      .done  (cor_done),
      .angle (cor_angle)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // Sequencer: each step takes the last unit's result and launches the next operation.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      axis_in  = axis_ff;
      ecc_in   = ecc_ff;
      tol_in   = tol_ff;
      lim_in   = lim_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      zin_in   = zin_ff;
      z_in     = z_ff;
      zk_in    = zk_ff;
      v_in     = v_ff;
      s_in     = s_ff;
      h_in     = h_ff;
      r2_in    = r2_ff;
      it_in    = it_ff;
      nc_in    = nc_ff;
      lat_in   = lat_ff;
      lon_in   = lon_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      opn_in   = opn_ff;
      mul_go_in  = 1'b0;
      div_go_in  = 1'b0;
      sqrt_go_in = 1'b0;
      cor_go_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_lat_in   = rsp_lat_ff;
      rsp_lon_in   = rsp_lon_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_nc_in    = rsp_nc_ff;
      diff = z_ff - zk_ff;
      mid  = mul_prod[FRAC+WORD_BITS-1:FRAC];
      hd   = sqrt_root - v_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_valid) begin
         case (csr_index)
            REG_AXIS: axis_in = csr_data[AXIS_BITS-1:0];
            REG_ECC:  ecc_in  = csr_data[ECC_BITS-1:0];
            REG_TOL:  tol_in  = csr_data[TOL_BITS-1:0];
            REG_LIM:  lim_in  = csr_data[LIM_BITS-1:0];
            default:  axis_in = axis_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in   = sext(req_tdata[COORD_BITS-1:0]);
               y_in   = sext(req_tdata[2*COORD_BITS-1:COORD_BITS]);
               zin_in = sext(req_tdata[3*COORD_BITS-1:2*COORD_BITS]);
               opa_in = mag64(sext(req_tdata[COORD_BITS-1:0]));
               opb_in = mag64(sext(req_tdata[COORD_BITS-1:0]));
               mul_go_in = 1'b1;
               ret_in    = S_R2B;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mul_done || div_done || sqrt_done || cor_done) begin
               state_in = ret_ff;
            end
         end
         S_R2B: begin
            r2_in  = mul_prod;
            opa_in = mag64(y_ff);
            opb_in = mag64(y_ff);
            mul_go_in = 1'b1;
            ret_in    = S_R2C;
            state_in  = S_WAIT;
         end
         // Radius squared in the equatorial plane; refinement starts from the input z.
         S_R2C: begin
            r2_in = r2_ff + mul_prod;
            z_in  = zin_ff;
            zk_in = '0;
            v_in  = {{(WORD_BITS-AXIS_BITS){1'b0}}, axis_ff};
            it_in = '0;
            nc_in = 1'b0;
            state_in = S_CHECK;
         end
         // Convergence test, then either another pass or the height.
         S_CHECK: begin
            if (mag64(diff) < {{(WORD_BITS-TOL_BITS){1'b0}}, tol_ff}) begin
               opa_in = mag64(z_ff);
               opb_in = mag64(z_ff);
               ret_in = S_HSQ;
            end else if (it_ff >= lim_ff) begin
               nc_in  = 1'b1;
               opa_in = mag64(z_ff);
               opb_in = mag64(z_ff);
               ret_in = S_HSQ;
            end else begin
               it_in  = it_ff + 1'b1;
               zk_in  = z_ff;
               opa_in = mag64(z_ff);
               opb_in = mag64(z_ff);
               ret_in = S_DSQ;
            end
            mul_go_in = 1'b1;
            state_in  = S_WAIT;
         end
         S_DSQ: begin
            opn_in     = r2_ff + mul_prod;
            sqrt_go_in = 1'b1;
            ret_in     = S_SDIV;
            state_in   = S_WAIT;
         end
         // sin(phi) = |zk| / d, taken as zero when the radius is zero.
         S_SDIV: begin
            if (sqrt_root == '0) begin
               s_in     = '0;
               state_in = S_S2;
            end else begin
               opn_in    = {24'd0, mag64(zk_ff), 40'd0};
               opa_in    = sqrt_root;
               div_go_in = 1'b1;
               ret_in    = S_SCLAMP;
               state_in  = S_WAIT;
            end
         end
         S_SCLAMP: begin
            s_in     = (div_quot > ONE_Q) ? ONE_Q : div_quot;
            state_in = S_S2;
         end
         S_S2: begin
            opa_in    = s_ff;
            opb_in    = s_ff;
            mul_go_in = 1'b1;
            ret_in    = S_T;
            state_in  = S_WAIT;
         end
         S_T: begin
            opa_in    = {{(WORD_BITS-ECC_BITS){1'b0}}, ecc_ff};
            opb_in    = mid;
            mul_go_in = 1'b1;
            ret_in    = S_SQ;
            state_in  = S_WAIT;
         end
         S_SQ: begin
            opn_in     = {24'd0, ONE_Q - mid, 40'd0};
            sqrt_go_in = 1'b1;
            ret_in     = S_V;
            state_in   = S_WAIT;
         end
         // Prime-vertical radius v = a / sqrt(1 - e2 sin^2).
         S_V: begin
            opn_in    = {{(WIDE_BITS-AXIS_BITS-FRAC){1'b0}}, axis_ff, 40'd0};
            opa_in    = sqrt_root;
            div_go_in = 1'b1;
            ret_in    = S_C1;
            state_in  = S_WAIT;
         end
         S_C1: begin
            v_in      = div_quot;
            opa_in    = div_quot;
            opb_in    = {{(WORD_BITS-ECC_BITS){1'b0}}, ecc_ff};
            mul_go_in = 1'b1;
            ret_in    = S_C2;
            state_in  = S_WAIT;
         end
         S_C2: begin
            opa_in    = mid;
            opb_in    = s_ff;
            mul_go_in = 1'b1;
            ret_in    = S_ZUP;
            state_in  = S_WAIT;
         end
         S_ZUP: begin
            z_in     = zk_ff[WORD_BITS-1] ? (zin_ff - mid) : (zin_ff + mid);
            state_in = S_CHECK;
         end
         S_HSQ: begin
            opn_in     = r2_ff + mul_prod;
            sqrt_go_in = 1'b1;
            ret_in     = S_HDONE;
            state_in   = S_WAIT;
         end
         // Height with saturation; the polar axis has fixed angles.
         S_HDONE: begin
            if ($signed(hd) > $signed(H_MAX)) begin
               h_in = H_MAX;
            end else if ($signed(hd) < $signed(H_MIN)) begin
               h_in = H_MIN;
            end else begin
               h_in = hd;
            end
            if (r2_ff == '0) begin
               lat_in = ($signed(zin_ff) > 0) ? angle_field(HALF_PI_U)
                                              : angle_field(~HALF_PI_U + 64'd1);
               lon_in   = '0;
               state_in = S_OUT;
            end else begin
               opn_in     = r2_ff;
               sqrt_go_in = 1'b1;
               ret_in     = S_RHO;
               state_in   = S_WAIT;
            end
         end
         S_RHO: begin
            opa_in    = z_ff;
            opb_in    = sqrt_root;
            cor_go_in = 1'b1;
            ret_in    = S_LAT;
            state_in  = S_WAIT;
         end
         S_LAT: begin
            lat_in    = angle_field(cor_angle);
            opa_in    = y_ff;
            opb_in    = x_ff;
            cor_go_in = 1'b1;
            ret_in    = S_LON;
            state_in  = S_WAIT;
         end
         S_LON: begin
            lon_in   = angle_field(cor_angle);
            state_in = S_OUT;
         end
         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_lat_in   = lat_ff;
               rsp_lon_in   = lon_ff;
               rsp_h_in     = h_ff[COORD_BITS-1:0];
               rsp_nc_in    = nc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         axis_ff      <= AXIS_RESET;
         ecc_ff       <= ECC_RESET;
         tol_ff       <= TOL_RESET;
         lim_ff       <= LIM_RESET;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         sqrt_go_ff   <= 1'b0;
         cor_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         axis_ff      <= axis_in;
         ecc_ff       <= ecc_in;
         tol_ff       <= tol_in;
         lim_ff       <= lim_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         sqrt_go_ff   <= sqrt_go_in;
         cor_go_ff    <= cor_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      zin_ff     <= zin_in;
      z_ff       <= z_in;
      zk_ff      <= zk_in;
      v_ff       <= v_in;
      s_ff       <= s_in;
      h_ff       <= h_in;
      r2_ff      <= r2_in;
      it_ff      <= it_in;
      nc_ff      <= nc_in;
      lat_ff     <= lat_in;
      lon_ff     <= lon_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      opn_ff     <= opn_in;
      rsp_lat_ff <= rsp_lat_in;
      rsp_lon_ff <= rsp_lon_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_nc_ff  <= rsp_nc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_h_ff, rsp_lon_ff, rsp_lat_ff};
   assign rsp_tuser  = rsp_nc_ff;

endmodule

// ----- sim/ecef_to_geodetic_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, response and register channels of the core, works out the
// expected geodetic result of every accepted request and compares it with the responses.
module ecef_to_geodetic_checker
   import e2g_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [119:0]              req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [103:0]              rsp_tdata,
   input  logic                      rsp_tuser,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        failures,
   output int                        pending
);

   typedef struct packed {
      logic [31:0] lat;
      logic [31:0] lon;
      logic [37:0] height;
      logic        nc;
   } geo_type;

   localparam logic signed [63:0] HALF_S = 64'sd1 <<< 60;
   localparam logic signed [63:0] PI_S   = 64'sd1 <<< 61;
   localparam logic signed [63:0] H_MAX  = (64'sd1 <<< 37) - 64'sd1;
   localparam logic signed [63:0] H_MIN  = -(64'sd1 <<< 37);

   geo_type              geo_q[$];
   logic [63:0]          rot_tab [CORDIC_N];
   logic [AXIS_BITS-1:0] axis_r;
   logic [ECC_BITS-1:0]  ecc_r;
   logic [TOL_BITS-1:0]  tol_r;
   logic [LIM_BITS-1:0]  lim_r;

   // Arctangent table of the rotation steps, in units of pi/2^61.
   initial begin
      logic [63:0]  sum;
      logic [63:0]  term;
      logic [127:0] prod;
      int           e;
      failures   = 0;
      rot_tab[0] = 64'd1 << 59;
      for (int i = 1; i < CORDIC_N; i++) begin
         sum = '0;
         for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
               term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
               if (k % 2 == 1) sum = sum - term;
               else sum = sum + term;
            end
         end
         prod       = {64'd0, sum} * {64'd0, TWO_OVER_PI};
         rot_tab[i] = prod[127:64] >> 2;
      end
   end

   function automatic logic [63:0] absval(logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] res;
      logic [63:0] c;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         c = res | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) res = c;
      end
      return res;
   endfunction

   // Quotient saturated to 64 bits; a zero divisor gives all ones.
   function automatic logic [63:0] quot_sat(logic [127:0] n, logic [63:0] d);
      logic [127:0] q;
      if (d == 0) return '1;
      q = n / {64'd0, d};
      return (q[127:64] != 0) ? '1 : q[63:0];
   endfunction

   // Vectoring rotation: atan2(py, px) in units of pi/2^61.
   function automatic logic signed [63:0] bearing(logic signed [63:0] py,
                                                  logic signed [63:0] px);
      logic [63:0]        ax;
      logic [63:0]        ay;
      logic [63:0]        m;
      logic signed [63:0] rx;
      logic signed [63:0] ry;
      logic signed [63:0] acc;
      logic signed [63:0] nx;
      ax = absval(px);
      ay = absval(py);
      if (ax == 0 && ay == 0) return 0;
      m = ax > ay ? ax : ay;
      while (m >= (64'd1 << 58)) begin
         ax = ax >> 1; ay = ay >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 57)) begin
         ax = ax << 1; ay = ay << 1; m = m << 1;
      end
      rx  = ax;
      ry  = ay;
      acc = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
         if (ry >= 0) begin
            nx  = rx + (ry >>> i);
            ry  = ry - (rx >>> i);
            acc = acc + $signed(rot_tab[i]);
         end else begin
            nx  = rx - (ry >>> i);
            ry  = ry + (rx >>> i);
            acc = acc - $signed(rot_tab[i]);
         end
         rx = nx;
      end
      if (acc < 0) acc = 0;
      if (acc > HALF_S) acc = HALF_S;
      if (px < 0) acc = PI_S - acc;
      if (py < 0) acc = -acc;
      return acc;
   endfunction

   // Round half away from zero to the 32-bit binary angle.
   function automatic logic [31:0] to_bam(logic signed [63:0] a);
      logic [63:0] r;
      r = (absval(a) + (64'd1 << 29)) >> 30;
      return a < 0 ? 32'(-r) : r[31:0];
   endfunction

   function automatic geo_type convert(logic [119:0] d);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] zin;
      logic signed [63:0] z;
      logic signed [63:0] zk;
      logic signed [63:0] h;
      logic [127:0]       r2;
      logic [127:0]       p;
      logic [63:0]        v;
      logic [63:0]        az;
      logic [63:0]        radius;
      logic [63:0]        s;
      logic [63:0]        s2;
      logic [63:0]        t;
      logic [63:0]        sq;
      logic [63:0]        corr;
      logic [63:0]        hyp;
      int                 passes;
      geo_type            g;
      x   = {{26{d[37]}}, d[37:0]};
      y   = {{26{d[75]}}, d[75:38]};
      zin = {{26{d[113]}}, d[113:76]};
      r2  = {64'd0, absval(x)} * {64'd0, absval(x)} + {64'd0, absval(y)} * {64'd0, absval(y)};
      v      = {27'd0, axis_r};
      g.nc   = 1'b0;
      passes = 0;
      z      = zin;
      zk     = 0;
      // Refine the auxiliary z until it settles or the pass budget runs out.
      forever begin
         if (absval(z - zk) < {54'd0, tol_r}) break;
         if (passes >= lim_r) begin
            g.nc = 1'b1;
            break;
         end
         passes++;
         zk     = z;
         az     = absval(zk);
         radius = root_floor(r2 + {64'd0, az} * {64'd0, az});
         s      = radius != 0 ? quot_sat({64'd0, az} << FRAC, radius) : 64'd0;
         if (s > ONE_Q) s = ONE_Q;
         p    = {64'd0, s} * {64'd0, s};
         s2   = p[103:40];
         p    = {88'd0, ecc_r} * {64'd0, s2};
         t    = p[103:40];
         sq   = root_floor({64'd0, ONE_Q - t} << FRAC);
         v    = quot_sat({91'd0, axis_r} << FRAC, sq);
         p    = {64'd0, v} * {88'd0, ecc_r};
         p    = {64'd0, p[103:40]} * {64'd0, s};
         corr = p[103:40];
         z    = zk < 0 ? zin - $signed(corr) : zin + $signed(corr);
      end
      hyp = root_floor(r2 + {64'd0, absval(z)} * {64'd0, absval(z)});
      h   = $signed(hyp) - $signed(v);
      if (h > H_MAX) h = H_MAX;
      if (h < H_MIN) h = H_MIN;
      g.height = h[37:0];
      // On the polar axis the latitude is a right angle by the sign of z.
      if (r2 == 0) begin
         g.lat = to_bam(zin > 0 ? HALF_S : -HALF_S);
         g.lon = '0;
      end else begin
         g.lat = to_bam(bearing(z, $signed(root_floor(r2))));
         g.lon = to_bam(bearing(y, x));
      end
      return g;
   endfunction

   // Follow the three channels on each edge.
   always @(posedge clock) begin
      geo_type want;
      geo_type got;
      if (reset) begin
         axis_r = AXIS_RESET;
         ecc_r  = ECC_RESET;
         tol_r  = TOL_RESET;
         lim_r  = LIM_RESET;
         geo_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_AXIS: axis_r = csr_data[AXIS_BITS-1:0];
               REG_ECC:  ecc_r  = csr_data[ECC_BITS-1:0];
               REG_TOL:  tol_r  = csr_data[TOL_BITS-1:0];
               REG_LIM:  lim_r  = csr_data[LIM_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) geo_q.push_back(convert(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.lat    = rsp_tdata[31:0];
            got.lon    = rsp_tdata[63:32];
            got.height = rsp_tdata[101:64];
            got.nc     = rsp_tuser;
            if (geo_q.size() == 0) begin
               $display("%0t: response with none expected: lat %h lon %h h %h nc %b",
                        $time, got.lat, got.lon, got.height, got.nc);
               failures++;
            end else begin
               want = geo_q.pop_front();
               if (got.lat !== want.lat) begin
                  $display("%0t: latitude expected %h actual %h", $time, want.lat, got.lat);
                  failures++;
               end
               if (got.lon !== want.lon) begin
                  $display("%0t: longitude expected %h actual %h", $time, want.lon, got.lon);
                  failures++;
               end
               if (got.height !== want.height) begin
                  $display("%0t: height expected %h actual %h", $time, want.height,
                           got.height);
                  failures++;
               end
               if (got.nc !== want.nc) begin
                  $display("%0t: not_converged expected %b actual %b", $time, want.nc, got.nc);
                  failures++;
               end
            end
         end
      end
      pending = geo_q.size();
   end

endmodule

// ----- sim/tb_ecef_to_geodetic_core.sv -----
`timescale 1ns / 1ps

// Drives positions and register settings into the core and gives the verdict.
module tb_ecef_to_geodetic_core;
   import e2g_pkg::*;

   localparam longint CYCLE_LIMIT = 200_000_000;
   localparam int     LONG_HOLD   = 30000;
   localparam int     PHASE_ITEMS = 220;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [119:0]              req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [103:0]              rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        failures;
   int                        pending;
   bit                        idle_on;
   bit                        hold_rsp;
   longint                    cycles;

   ecef_to_geodetic_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   ecef_to_geodetic_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the cycle count.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("** ecef_to_geodetic_core: FAILED **");
            $finish;
         end
      end
   end

   // Response side: short random stalls, and one long hold-off on demand.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request, with an occasional gap in front of it.
   task automatic send_pos(logic [37:0] x, logic [37:0] y, logic [37:0] z);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [37:0] rand_coord();
      logic [63:0] m;
      logic [37:0] c;
      case ($urandom_range(0, 9))
         0, 1: c = 38'({$urandom, $urandom});
         2, 3, 4, 5, 6: begin
            m = {$urandom, $urandom} % 64'd70000000000;
            c = m[37:0];
         end
         7: c = 38'($urandom_range(0, 1000));
         8: c = '0;
         default: c = $urandom_range(0, 1) ? 38'h1f_ffff_ffff : 38'h20_0000_0000;
      endcase
      if ($urandom_range(0, 1)) c = -c;
      return c;
   endfunction

   task automatic send_random();
      logic [37:0] x;
      logic [37:0] y;
      x = rand_coord();
      y = rand_coord();
      // Now and then put the position on the polar axis.
      if ($urandom_range(0, 19) == 0) begin
         x = '0;
         y = '0;
      end
      send_pos(x, y, rand_coord());
   endtask

   // Settle the block, load all four registers, then run random requests.
   task automatic run_phase(logic [39:0] axis, logic [39:0] ecc, logic [39:0] tol,
                            logic [39:0] lim, int n);
      drain();
      write_reg(REG_AXIS, axis);
      write_reg(REG_ECC, ecc);
      write_reg(REG_TOL, tol);
      write_reg(REG_LIM, lim);
      repeat (n) send_random();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      idle_on    = 1'b1;
      hold_rsp   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed positions at the reset settings.
      send_pos(38'd63781370000, 38'd0, 38'd0);
      send_pos(38'd0, 38'd0, 38'd63567523142);
      send_pos(38'd0, 38'd0, -38'd63567523142);
      send_pos(38'd0, 38'd0, 38'd0);
      send_pos(-38'd45000000000, 38'd0, 38'd1000);
      send_pos(-38'd1, 38'd0, 38'd0);
      send_pos(38'h1f_ffff_ffff, 38'h1f_ffff_ffff, 38'h1f_ffff_ffff);
      send_pos(38'h20_0000_0000, 38'h20_0000_0000, 38'h20_0000_0000);
      send_pos(38'h1f_ffff_ffff, 38'h20_0000_0000, 38'd0);
      send_pos(38'd1, 38'd1, 38'd1);
      send_pos(38'd40000000000, -38'd30000000000, 38'd35000000000);
      send_pos(38'd0, 38'd63781370000, -38'd5);
      send_pos(38'd0, -38'd1, 38'd0);

      // Let every response come back before the next settings.
      drain();
      write_reg(REG_AXIS, 40'd63781370000);
      write_reg(REG_ECC, 40'd7360548640);
      write_reg(REG_TOL, 40'd1);
      write_reg(REG_LIM, 40'd10);
      // Hold the response side off while requests keep coming.
      hold_rsp = 1'b1;
      repeat (6) send_random();

      run_phase(40'h1f_ffff_ffff, 40'hff_ffff_ffff, 40'd1000, 40'd1, PHASE_ITEMS);
      run_phase(40'd0, 40'd0, 40'd1, 40'd31, PHASE_ITEMS);
      run_phase(40'd63781370000, 40'd7360548640, 40'd0, 40'd2, PHASE_ITEMS);
      run_phase(40'd63781370000, 40'd7360548640, 40'd5, 40'd0, PHASE_ITEMS);
      run_phase(40'd63781370000, 40'd7360548640, 40'($urandom_range(1, 1023)), 40'd4,
                PHASE_ITEMS);
      run_phase(40'({$urandom, $urandom} & 64'h1f_ffff_ffff),
                40'({$urandom, $urandom} & 64'h00_3fff_ffff),
                40'($urandom_range(0, 1023)), 40'($urandom_range(1, 5)), PHASE_ITEMS);
      run_phase(40'd63781370000, 40'($urandom_range(0, 32'hffff_ffff)),
                40'($urandom_range(1, 100)), 40'($urandom_range(2, 31)), PHASE_ITEMS);
      // Last stretch without idling on either side.
      drain();
      idle_on = 1'b0;
      run_phase(40'd63781370000, 40'd7360548640, 40'd1, 40'd10, PHASE_ITEMS);

      drain();
      repeat (3000) @(posedge clock);
      if (failures == 0) begin
         $display("** ecef_to_geodetic_core: PASSED **");
      end else begin
         $display("** ecef_to_geodetic_core: FAILED **");
      end
      $finish;
   end

endmodule
